>>> design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg: constants and types for the degree-input sine unit
// Fixed-point formats, datapath widths and folding constants.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // Datapath widths
  localparam int unsigned VAL_W     = 48;  // x, x^2 and term magnitudes, Q8.40
  localparam int unsigned OPND_W    = 64;  // multiplier operand, two 32-bit halves
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned PROD_W    = 96;  // full product
  localparam int unsigned NUM_W     = 56;  // divider numerator / quotient
  localparam int unsigned ACC_W     = 52;  // signed series sum, Q12.40
  localparam int unsigned DIV_BITS  = 8;   // quotient bits per divider cycle
  localparam int unsigned DIV_STEPS = NUM_W / DIV_BITS;
  localparam int unsigned RED_STEPS = 7;   // quotient of a turn fold stays below 128

  // Folding and scaling constants
  localparam logic [31:0] FULL_TURN_Q16   = 32'd23592960;   // 360.0 in Q16.16
  localparam logic [31:0] NEG_FOLD_LIMIT  = 32'd4271374336; // 2^32 - 360.0
  localparam logic [63:0] RAD_PER_DEG_Q38 = 64'd4797524517; // pi/180 in Q0.38
  localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

  // What the product in flight is for
  typedef enum logic [1:0] {
    MK_SCALE,
    MK_SQUARE,
    MK_TERM
  } mul_kind_e;

endpackage

>>> design/sine_degrees_taylor.sv
// ----------------------------------------------------------------------------
// sine_degrees_taylor: sine of a Q16.16 angle in degrees, result in Q2.30
// Usage:
//   Input channel  in_valid_i / in_ready_o carries angle_deg_i (signed Q16.16).
//   Output channel out_valid_o / out_ready_i carries sine_value_o (signed
//   Q2.30, clamped to +-1.0). One result beat for every input beat.
//   in_ready_o is high only while the sequencer is idle. After an accepted
//   beat the sequencer folds the angle, scales it to radians, squares it and
//   sums the series before the result is valid; a new angle can be taken once
//   it returns to idle. The run time is set by the shared 32x32 multiplier
//   (four partial products per 64-bit product), the radix-256 divider that
//   scales each series term, the turn fold, radian scaling and squaring.
//   The result sits in an output register; a new angle may be accepted while
//   it waits. If the receiver stalls, the finished next result is held in
//   the sequencer until the register frees.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   any pending result beat.
// ----------------------------------------------------------------------------
module sine_degrees_taylor #(
  parameter int unsigned TERMS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] angle_deg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_value_o
);

  localparam int unsigned VW   = sdt_pkg::VAL_W;
  localparam int unsigned OW   = sdt_pkg::OPND_W;
  localparam int unsigned HW   = sdt_pkg::HALF_W;
  localparam int unsigned PW   = sdt_pkg::PROD_W;
  localparam int unsigned NW   = sdt_pkg::NUM_W;
  localparam int unsigned AW   = sdt_pkg::ACC_W;
  localparam int unsigned QW   = AW - 10;
  localparam int unsigned IW   = $clog2(TERMS);
  localparam int unsigned KW   = $clog2(2 * TERMS + 2);
  localparam int unsigned DMAX = (2 * TERMS + 1) * (2 * TERMS);
  localparam int unsigned DW   = $clog2(DMAX + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [2:0] MSTEP_LAST = 3'd4;

  // Control registers
  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          red_cnt_q, red_cnt_d;
  logic [2:0]          mstep_q, mstep_d;
  logic [2:0]          div_cnt_q, div_cnt_d;
  logic [IW-1:0]       i_q, i_d;
  sdt_pkg::mul_kind_e  kind_q, kind_d;

  // Datapath registers
  logic [31:0]         mag_q, mag_d;
  logic                neg_in_q, neg_in_d;
  logic                big_q, big_d;
  logic [OW-1:0]       a_q, a_d;
  logic [OW-1:0]       b_q, b_d;
  logic [2*HW-1:0]     pp_q, pp_d;
  logic [1:0]          pp_sh_q, pp_sh_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [VW-1:0]       x_q, x_d;
  logic [VW-1:0]       x2_q, x2_d;
  logic [VW-1:0]       t_q, t_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic                neg_acc_q, neg_acc_d;
  logic [NW-1:0]       num_q, num_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [KW-1:0]       k_q, k_d;
  logic [DW-1:0]       d_q, d_d;
  logic [31:0]         out_data_q, out_data_d;

  // Combinational helpers
  logic [31:0]         red_sub;
  logic [HW-1:0]       mul_x, mul_y;
  logic [PW-1:0]       pp_aligned;
  logic [PW-1:0]       post_add, post_sum;
  logic [NW-1:0]       dv_num;
  logic [DW-1:0]       dv_rem;
  logic [DW:0]         dv_tmp;
  logic [AW-1:0]       rnd;
  logic [QW-1:0]       q_full;
  logic [30:0]         q_sat;
  logic                neg_out;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sine_value_o = out_data_q;

  // Shared multiplier operand select: lo*lo, lo*hi, hi*lo, hi*hi
  assign mul_x   = mstep_q[1] ? a_q[OW-1:HW] : a_q[HW-1:0];
  assign mul_y   = mstep_q[0] ? b_q[OW-1:HW] : b_q[HW-1:0];
  assign red_sub = sdt_pkg::FULL_TURN_Q16 << red_cnt_q;

  always_comb begin
    case (pp_sh_q)
      2'd1:    pp_aligned = PW'(pp_q) << HW;
      2'd2:    pp_aligned = PW'(pp_q) << (2 * HW);
      default: pp_aligned = PW'(pp_q);
    endcase
  end

  // Rounding addend; the divider's half-divisor rides above the Q8.40 point
  always_comb begin
    case (kind_q)
      sdt_pkg::MK_SCALE:  post_add = PW'(1) << 13;
      sdt_pkg::MK_SQUARE: post_add = PW'(1) << 39;
      default:            post_add = (PW'(d_q[DW-1:1]) << 40) | (PW'(1) << 39);
    endcase
    post_sum = prod_q + post_add;
  end

  // Radix-256 restoring division step by the term divisor
  always_comb begin
    dv_num = num_q;
    dv_rem = rem_q;
    dv_tmp = '0;
    for (int b = 0; b < sdt_pkg::DIV_BITS; b++) begin
      dv_tmp = {dv_rem, dv_num[NW-1]};
      dv_num = {dv_num[NW-2:0], 1'b0};
      if (dv_tmp >= {1'b0, d_q}) begin
        dv_tmp    = dv_tmp - {1'b0, d_q};
        dv_num[0] = 1'b1;
      end
      dv_rem = dv_tmp[DW-1:0];
    end
  end

  // Output rounding, clamp and sign
  always_comb begin
    rnd     = acc_q + AW'(512);
    q_full  = rnd[AW-1:10];
    q_sat   = (q_full > QW'(sdt_pkg::ONE_Q30)) ? sdt_pkg::ONE_Q30 : q_full[30:0];
    neg_out = (neg_in_q != neg_acc_q) && (q_sat != '0);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    red_cnt_d   = red_cnt_q;
    mstep_d     = mstep_q;
    div_cnt_d   = div_cnt_q;
    i_d         = i_q;
    kind_d      = kind_q;
    mag_d       = mag_q;
    neg_in_d    = neg_in_q;
    big_d       = big_q;
    a_d         = a_q;
    b_d         = b_q;
    pp_d        = pp_q;
    pp_sh_d     = pp_sh_q;
    prod_d      = prod_q;
    x_d         = x_q;
    x2_d        = x2_q;
    t_d         = t_q;
    acc_d       = acc_q;
    neg_acc_d   = neg_acc_q;
    num_d       = num_q;
    rem_d       = rem_q;
    k_d         = k_q;
    d_d         = d_q;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_in_d  = angle_deg_i[31];
          mag_d     = angle_deg_i[31] ? (~angle_deg_i + 32'd1) : angle_deg_i;
          big_d     = angle_deg_i[31] ? (angle_deg_i < sdt_pkg::NEG_FOLD_LIMIT)
                                      : (angle_deg_i > sdt_pkg::FULL_TURN_Q16);
          red_cnt_d = 3'(sdt_pkg::RED_STEPS - 1);
          state_d   = ST_RED;
        end
      end
      ST_RED: begin
        // drop whole turns only when the magnitude is above one turn
        if (big_q && (mag_q >= red_sub)) begin
          mag_d = mag_q - red_sub;
        end
        red_cnt_d = red_cnt_q - 3'd1;
        if (red_cnt_q == 3'd0) begin
          a_d     = OW'(mag_d);
          b_d     = sdt_pkg::RAD_PER_DEG_Q38;
          kind_d  = sdt_pkg::MK_SCALE;
          mstep_d = 3'd0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mstep_q != MSTEP_LAST) begin
          pp_d    = mul_x * mul_y;
          pp_sh_d = 2'({1'b0, mstep_q[1]} + {1'b0, mstep_q[0]});
        end
        prod_d  = (mstep_q == 3'd0) ? '0 : (prod_q + pp_aligned);
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == MSTEP_LAST) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        case (kind_q)
          sdt_pkg::MK_SCALE: begin
            x_d     = post_sum[14 +: VW];
            a_d     = OW'(x_d);
            b_d     = OW'(x_d);
            kind_d  = sdt_pkg::MK_SQUARE;
            mstep_d = 3'd0;
            state_d = ST_MUL;
          end
          sdt_pkg::MK_SQUARE: begin
            x2_d    = post_sum[40 +: VW];
            t_d     = x_q;
            acc_d   = '0;
            i_d     = '0;
            k_d     = KW'(3);
            d_d     = DW'(6);
            state_d = ST_ACC;
          end
          default: begin
            num_d     = post_sum[40 +: NW];
            rem_d     = '0;
            div_cnt_d = 3'd0;
            state_d   = ST_DIV;
          end
        endcase
      end
      ST_ACC: begin
        acc_d = i_q[0] ? (acc_q - AW'(t_q)) : (acc_q + AW'(t_q));
        if (i_q == IW'(TERMS - 1)) begin
          state_d = ST_FIN;
        end else begin
          a_d     = OW'(t_q);
          b_d     = OW'(x2_q);
          kind_d  = sdt_pkg::MK_TERM;
          mstep_d = 3'd0;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        num_d     = dv_num;
        rem_d     = dv_rem;
        div_cnt_d = div_cnt_q + 3'd1;
        if (div_cnt_q == 3'(sdt_pkg::DIV_STEPS - 1)) begin
          t_d     = dv_num[VW-1:0];
          i_d     = i_q + IW'(1);
          // next divisor (k+2)(k+1) = k(k-1) + 4k + 2
          d_d     = d_q + DW'({k_q, 2'b10});
          k_d     = k_q + KW'(2);
          state_d = ST_ACC;
        end
      end
      ST_FIN: begin
        neg_acc_d = acc_q[AW-1];
        acc_d     = acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register frees
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = neg_out ? (~{1'b0, q_sat} + 32'd1) : {1'b0, q_sat};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      red_cnt_q   <= '0;
      mstep_q     <= '0;
      div_cnt_q   <= '0;
      i_q         <= '0;
      kind_q      <= sdt_pkg::MK_SCALE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      red_cnt_q   <= red_cnt_d;
      mstep_q     <= mstep_d;
      div_cnt_q   <= div_cnt_d;
      i_q         <= i_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_in_q   <= neg_in_d;
    big_q      <= big_d;
    a_q        <= a_d;
    b_q        <= b_d;
    pp_q       <= pp_d;
    pp_sh_q    <= pp_sh_d;
    prod_q     <= prod_d;
    x_q        <= x_d;
    x2_q       <= x2_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    neg_acc_q  <= neg_acc_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    k_q        <= k_d;
    d_q        <= d_d;
    out_data_q <= out_data_d;
  end

  // Assertions
  a_accept_starts_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RED))
    else $error("accepted beat did not start the turn fold");

  a_div_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < d_q))
    else $error("divider remainder not below divisor");

  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sine_value_o <= 32'sd1073741824) &&
                     (sine_value_o >= -32'sd1073741824)))
    else $error("result beyond +-1.0");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && out_valid_o && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("pending result dropped while output stalled");

endmodule
